### sv/acmm_pkg.sv
// Package for the channel matrix mixer: widths, coefficient codes,
// mix table lookup and sequencer state type. No dependencies.
package acmm_pkg;
  localparam int MaxCh = 8;
  localparam int SampleW = 16;
  localparam int CoefFrac = 15;
  localparam int ChW = 3;
  localparam int CfgW = 4;
  localparam int AccW = 40;

  localparam logic CFG_SRC = 1'b0;
  localparam logic CFG_DST = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_OUT} state_t;

  // coefficient codes
  localparam logic [3:0] C0 = 4'd0, C1 = 4'd1, CH = 4'd2, CQ = 4'd3,
    CT = 4'd4, CA = 4'd5, CB = 4'd6, CX = 4'd7, CS = 4'd8;

  function automatic logic [16:0] code_coef(input logic [3:0] c);
    case (c)
      C1: code_coef = 17'd32768;
      CH: code_coef = 17'd16384;
      CQ: code_coef = 17'd8192;
      CT: code_coef = 17'd10912;
      CA: code_coef = 17'd9830;
      CB: code_coef = 17'd6554;
      CX: code_coef = 17'd5439;
      CS: code_coef = 17'd4686;
      default: code_coef = 17'd0;
    endcase
  endfunction

  // one row of 8 codes; s,d,o are zero based
  function automatic logic [31:0] row_codes(input logic [2:0] s, input logic [2:0] d,
                                            input logic [2:0] o);
    logic [31:0] r1, z, h;
    r1 = 32'h1000_0000; // code order: input 0 in top nibble
    z  = 32'h0;
    h  = 32'h2200_0000;
    row_codes = z;
    case (s)
      3'd0: begin
        row_codes = (o != d || d < 3'd5) ? r1 : z;
      end
      3'd1: begin
        case (d)
          3'd0: row_codes = h;
          3'd1: row_codes = (o == 0) ? r1 : 32'h0100_0000;
          3'd2: row_codes = (o == 0) ? r1 : (o == 1) ? h : 32'h0100_0000;
          3'd3: row_codes = o[0] ? 32'h0100_0000 : r1;
          3'd4, 3'd5: row_codes = (o == 0) ? r1 : (o == 1) ? h : (o == 2) ? 32'h0100_0000 :
                         (o == 3) ? r1 : (o == 4) ? 32'h0100_0000 : z;
          3'd6: row_codes = (o == 0) ? r1 : (o == 1 || o == 5) ? h :
                         (o == 2 || o == 4) ? 32'h0100_0000 : (o == 3) ? r1 : z;
          default: row_codes = (o == 0 || o == 3 || o == 5) ? r1 : (o == 1) ? h :
                         (o == 2 || o == 4 || o == 6) ? 32'h0100_0000 : z;
        endcase
      end
      3'd2: begin
        case (d)
          3'd0: row_codes = 32'h4440_0000;
          3'd1: row_codes = (o == 0) ? h : 32'h0220_0000;
          3'd2: row_codes = (o == 0) ? r1 : (o == 1) ? 32'h0100_0000 : 32'h0010_0000;
          3'd3: row_codes = (o == 0) ? h : (o == 1) ? 32'h0220_0000 : (o == 2) ? r1 :
                         32'h0010_0000;
          3'd4, 3'd5, 3'd6: row_codes = (o == 0 || o == 3) ? r1 : (o == 1) ? 32'h0100_0000 :
                         (o == 2 || o == 4) ? 32'h0010_0000 : z;
          default: row_codes = (o == 0 || o == 3 || o == 5) ? r1 : (o == 1) ? 32'h0100_0000 :
                         (o == 2 || o == 4 || o == 6) ? 32'h0010_0000 : z;
        endcase
      end
      3'd3: begin
        case (d)
          3'd0: row_codes = 32'h3333_0000;
          3'd1: row_codes = (o == 0) ? 32'h2020_0000 : 32'h0202_0000;
          3'd2: row_codes = (o == 0) ? 32'h2020_0000 : (o == 1) ? h : 32'h0202_0000;
          3'd3: row_codes = r1 >> (4 * o);
          3'd4, 3'd5: row_codes = (o == 0) ? r1 : (o == 1) ? h :
                         (o < 5) ? (r1 >> (4 * (o - 3'd1))) : z;
          3'd6: row_codes = (o == 0) ? r1 : (o == 1) ? h : (o == 2) ? 32'h0100_0000 :
                         (o == 3) ? 32'h2020_0000 : (o == 4) ? 32'h0202_0000 : z;
          default: row_codes = (o == 0) ? r1 : (o == 1) ? h : (o == 2) ? 32'h0100_0000 :
                         (o == 3) ? 32'h2020_0000 : (o == 4) ? 32'h0202_0000 :
                         (o == 5) ? 32'h0010_0000 : (o == 6) ? 32'h0001_0000 : z;
        endcase
      end
      default: begin
        case (d)
          3'd0: row_codes = (s == 3'd6) ? 32'h7777_7700 : (s == 3'd7) ? 32'h8888_8880 :
                         32'h6666_6000;
          3'd1: row_codes = (s == 3'd7) ? ((o == 0) ? 32'h5506_0600 : 32'h0550_6060) :
                         ((o == 0) ? 32'h2303_0000 : 32'h0320_3000);
          3'd2: row_codes = (s == 3'd7) ? ((o == 0) ? 32'h2003_0300 :
                         (o == 1) ? 32'h0100_0000 : 32'h0020_3030) :
                         ((o == 0) ? 32'h2002_0000 : (o == 1) ? 32'h0100_0000 : 32'h0020_2000);
          3'd3: row_codes = (s == 3'd7) ? ((o == 0) ? 32'h2303_0000 : (o == 1) ? 32'h0320_3000 :
                         (o == 2) ? 32'h0002_0200 : 32'h0000_2020) :
                         ((o == 0) ? h : (o == 1) ? 32'h0220_0000 :
                         (o == 2) ? 32'h0001_0000 : 32'h0000_1000);
          3'd4: row_codes = (s == 3'd7 && o > 3'd2) ? ((o == 3) ? 32'h0002_0200 : 32'h0000_2020)
                         : r1 >> (4 * o);
          3'd5: begin
            if (s == 3'd7 && (o == 3 || o == 4))
              row_codes = (o == 3) ? 32'h0002_0200 : 32'h0000_2020;
            else if (o < 5) row_codes = r1 >> (4 * o);
            else row_codes = (s == 3'd4) ? z : (s == 3'd5) ? 32'h0000_0100 :
                         (s == 3'd6) ? 32'h0000_0010 : 32'h0000_0001;
          end
          3'd6: begin
            if (s == 3'd4 || s == 3'd5)
              row_codes = (o < 3) ? r1 >> (4 * o) : (o == 3) ? 32'h0202_0000 :
                         (o == 4) ? 32'h0020_2000 : (o == 5) ? 32'h0002_2000 :
                         (s == 3'd5) ? 32'h0000_0100 : z;
            else if (o < 5) row_codes = r1 >> (4 * o);
            else if (s == 3'd6) row_codes = (o == 5) ? 32'h0000_0100 : 32'h0000_0010;
            else row_codes = (o == 5) ? 32'h0000_0220 : 32'h0000_0001;
          end
          default: begin
            if (s == 3'd4 || s == 3'd5)
              row_codes = (o < 3) ? r1 >> (4 * o) : (o == 3) ? 32'h0202_0000 :
                         (o == 4) ? 32'h0020_2000 : (o == 5) ? 32'h0001_0000 :
                         (o == 6) ? 32'h0000_1000 : (s == 3'd5) ? 32'h0000_0100 : z;
            else if (o < 5) row_codes = r1 >> (4 * o);
            else if (s == 3'd6) row_codes = (o == 7) ? 32'h0000_0010 : 32'h0000_0100;
            else row_codes = (o == 5) ? 32'h0000_0100 : (o == 6) ? 32'h0000_0010 :
                         32'h0000_0001;
          end
        endcase
      end
    endcase
  endfunction
endpackage

### sv/audio_channel_matrix_mixer.sv
// Top level of the channel matrix mixer: frame buffer, sequencer, output register.
// Depends on acmm_pkg and acmm_mac.
//  channel | ports       | fields (low bit up)
//  in      | in_t*       | tdata: sample_in[15:0]
//  out     | out_t*      | tdata: out_channel[2:0], sample_out[18:3]; tlast: frame_last
//  cfg     | cfg_*       | index 0 src_channels, 1 dst_channels
// A partial-frame sample is written to the buffer. A closing sample runs one MAC step
// per source channel for each output channel on one shared multiplier, then one output
// transaction; out_tready low holds the sequencer. Reset is synchronous; no clearing pass.
module audio_channel_matrix_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_channel, sample_out
  output logic        out_tlast,  // frame_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import acmm_pkg::*;
  state_t st_r, st_nxt;
  logic [3:0] src_r, dst_r;
  logic [ChW-1:0] cnt_r, ci_r, co_r, ns1, nd1;
  logic [SampleW-1:0] buf_r [MaxCh];
  logic [SampleW-1:0] rd_smp;
  logic [31:0] row;
  logic [3:0] code;
  logic [SampleW-1:0] res;
  logic in_acc, last_in, mac_clr, mac_en;
  logic ovalid_r;
  logic [ChW-1:0] och_r;
  logic [SampleW-1:0] osmp_r;
  logic olast_r;

  assign ns1 = (src_r == 0) ? 3'd0 : (src_r > 4'd8) ? 3'd7 : ChW'(src_r - 4'd1);
  assign nd1 = (dst_r == 0) ? 3'd0 : (dst_r > 4'd8) ? 3'd7 : ChW'(dst_r - 4'd1);
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign last_in = (cnt_r == ns1);

  assign row = row_codes(ns1, nd1, co_r);
  assign code = row[31 - 4 * ci_r -: 4];
  assign rd_smp = buf_r[ci_r];

  acmm_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .smp($signed(rd_smp)),
                  .coef(code_coef(code)), .result(res));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc && last_in) st_nxt = ST_MAC;
      ST_MAC:  if (ci_r == ns1) st_nxt = ST_OUT;
      ST_OUT: begin
        if (!ovalid_r || out_tready) st_nxt = (co_r == nd1) ? ST_IDLE : ST_MAC;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_en = (st_r == ST_MAC);
    mac_clr = (st_r == ST_IDLE) || ((st_r == ST_OUT) && (!ovalid_r || out_tready));
  end

  always_ff @(posedge clk) begin
    if (in_acc) buf_r[cnt_r] <= in_tdata;
    if (st_r == ST_OUT && (!ovalid_r || out_tready)) begin
      och_r <= co_r;
      osmp_r <= res;
      olast_r <= (co_r == nd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; src_r <= 4'd2; dst_r <= 4'd2;
      cnt_r <= '0; ci_r <= '0; co_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_OUT && (!ovalid_r || out_tready)) begin
        ovalid_r <= 1'b1;
        co_r <= (co_r == nd1) ? '0 : co_r + 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      if (st_r == ST_MAC) ci_r <= (ci_r == ns1) ? '0 : ci_r + 1'b1;
      if (cfg_we) begin
        if (cfg_index == CFG_SRC) src_r <= cfg_wdata;
        else dst_r <= cfg_wdata;
        cnt_r <= '0;
      end else if (in_acc) begin
        cnt_r <= last_in ? '0 : cnt_r + 1'b1;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {5'd0, osmp_r, och_r};
  assign out_tlast = olast_r;
endmodule

### sv/acmm_mac.sv
// Shared multiply-accumulate unit with floor shift and saturation.
// Depends on acmm_pkg.
module acmm_mac (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          en,
  input  logic signed [acmm_pkg::SampleW-1:0] smp,
  input  logic [16:0]                   coef,
  output logic signed [acmm_pkg::SampleW-1:0] result
);
  import acmm_pkg::*;
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [17:0] coef_s;
  logic signed [33:0] mul;
  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] sh;

  assign coef_s = signed'({1'b0, coef});
  assign mul = coef_s * smp;
  assign prod = AccW'(mul);
  always_comb begin
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (en) acc_nxt = acc_r + prod;
  end
  always_ff @(posedge clk) acc_r <= acc_nxt;

  assign sh = acc_r >>> CoefFrac;
  always_comb begin
    if (sh > AccW'(32767)) result = 16'sh7fff;
    else if (sh < -AccW'(32768)) result = -16'sh8000;
    else result = sh[SampleW-1:0];
  end
endmodule
